[hw/rtl/rcfd_pkg.sv]
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared types and constants for the remote-control receiver frame decoder.
// ----------------------------------------------------------------------------
package rcfd_pkg;

   // Command codes on the request channel
   localparam logic [1:0] CMD_BYTE      = 2'd0;
   localparam logic [1:0] CMD_FRAME_END = 2'd1;
   localparam logic [1:0] CMD_TICK      = 2'd2;

   // Register indexes (byte address is 4 * index)
   localparam logic [1:0] REG_FAILSAFE_ENABLE = 2'd0;
   localparam logic [1:0] REG_TIMEOUT_TICKS   = 2'd1;
   localparam logic [1:0] REG_DEADZONE_WIDTH  = 2'd2;

   // Register reset values
   localparam logic        RST_FAILSAFE_ENABLE = 1'b1;
   localparam logic [15:0] RST_TIMEOUT_TICKS   = 16'd100;
   localparam logic [5:0]  RST_DEADZONE_WIDTH  = 6'd5;

   // Frame and failsafe constants
   localparam int unsigned FRAME_LEN     = 6;
   localparam logic [15:0] COUNT_MAX     = 16'd60000;
   localparam logic signed [11:0] CENTER = 12'sd1024;
   localparam logic signed [10:0] FS_YAW = -11'sd260;
   localparam logic [1:0]  FS_SW_LEFT    = 2'd3;
   localparam logic [1:0]  FS_SW_RIGHT   = 2'd2;
   localparam logic [1:0]  SW_LOCK       = 2'd2;

   // Operation carried through the queue
   typedef enum logic [1:0] {
      OP_BYTE      = 2'd0,
      OP_FRAME_END = 2'd1,
      OP_TICK      = 2'd2
   } op_type;

   // One queued operation
   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } entry_type;

   // Front-to-queue push request
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   // Queue status seen by its producer and consumer
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // Configuration as seen by the back end
   typedef struct packed {
      logic        failsafe_enable;
      logic [15:0] timeout_ticks;
      logic [5:0]  deadzone_width;
   } cfg_type;

endpackage

[hw/rtl/rcfd_front.sv]
// ----------------------------------------------------------------------------
// rcfd_front
// Input stage: accepts request transactions, drops unused commands, maps the
// command onto a queue operation and holds it until the queue has room.
// ----------------------------------------------------------------------------
module rcfd_front import rcfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_rx_byte,
   input  qstat_type  qstat,
   output push_type   push
);

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      accept;
   logic      keep;
   op_type    op_dec;
   logic      op_known;

   // Command classification
   always_comb begin
      op_known = 1'b1;
      op_dec   = OP_BYTE;
      case (req_cmd)
         CMD_BYTE:      op_dec = OP_BYTE;
         CMD_FRAME_END: op_dec = OP_FRAME_END;
         CMD_TICK:      op_dec = OP_TICK;
         default:       op_known = 1'b0;
      endcase
   end

   // Hold register: stalls only while a held entry cannot enter the queue
   assign keep      = valid_ff & qstat.full;
   assign req_stall = keep;
   assign accept    = req_valid & ~keep;

   always_comb begin
      valid_in = keep | (accept & op_known);
      entry_in = entry_ff;
      if (!keep) begin
         entry_in.op   = op_dec;
         entry_in.data = req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign push.valid = valid_ff & ~qstat.full;
   assign push.entry = entry_ff;

endmodule

[hw/rtl/rcfd_queue.sv]
// ----------------------------------------------------------------------------
// rcfd_queue
// Short FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module rcfd_queue import rcfd_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   input  logic      pop,
   output entry_type head,
   output qstat_type qstat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign qstat.full  = (count_ff == CNT_FULL);
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push.valid & ~qstat.full;
   assign do_pop      = pop & ~qstat.empty;
   assign head        = slot_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

`ifndef NO_ASSERTIONS
   // Occupancy never exceeds the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count above depth");

   // Pointers agree with the count when the queue is empty
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      qstat.empty |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue empty with unequal pointers");

   // A push alone raises the count by one
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow push");
`endif

endmodule

[hw/rtl/rcfd_back.sv]
// ----------------------------------------------------------------------------
// rcfd_back
// Execution stage: stores frame bytes, decodes frames, runs the silence
// counter and failsafe, and holds the result transaction for the receiver.
// ----------------------------------------------------------------------------
module rcfd_back import rcfd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  entry_type          head,
   input  qstat_type          qstat,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [10:0] rsp_stick_roll,
   output logic signed [10:0] rsp_stick_pitch,
   output logic signed [10:0] rsp_stick_throttle,
   output logic signed [10:0] rsp_stick_yaw,
   output logic [1:0]         rsp_switch_left,
   output logic [1:0]         rsp_switch_right,
   output logic               rsp_force_lock,
   output logic               rsp_out_of_control
);

   localparam logic [2:0] POS_FULL = 3'(FRAME_LEN);

   logic [7:0]         frame_ff [FRAME_LEN];
   logic [2:0]         pos_ff, pos_in;
   logic signed [10:0] stick_ff [4];
   logic signed [10:0] stick_in [4];
   logic [1:0]         sw_ff [2];
   logic [1:0]         sw_in [2];
   logic [15:0]        silence_ff, silence_in;
   logic               flag_ff, flag_in;
   logic               lock_ff, lock_in;
   logic               valid_ff, valid_in;
   logic               issue;
   logic               is_byte, is_frame, is_tick;
   logic [10:0]        raw [4];

   // Center on 1024 and pull toward zero by the deadzone width
   function automatic logic signed [10:0] shrink(input logic [10:0] r,
                                                 input logic [5:0]  dz);
      logic signed [11:0] v;
      logic signed [11:0] d;
      logic signed [11:0] t;
      v = $signed({1'b0, r}) - CENTER;
      d = $signed({6'b0, dz});
      if (v > 12'sd0) begin
         t = v - d;
         if (t < 12'sd0) t = 12'sd0;
      end else begin
         t = v + d;
         if (t > 12'sd0) t = 12'sd0;
      end
      return t[10:0];
   endfunction

   assign is_byte  = (head.op == OP_BYTE);
   assign is_frame = (head.op == OP_FRAME_END);
   assign is_tick  = (head.op == OP_TICK);

   // Bytes never produce a result, so they drain even while output stalls
   assign pop   = ~qstat.empty & (is_byte | ~valid_ff | ~rsp_stall);
   assign issue = pop;

   // Frame unpacking: four 11-bit sticks, little-endian bit order
   assign raw[0] = {frame_ff[1][2:0], frame_ff[0]};
   assign raw[1] = {frame_ff[2][5:0], frame_ff[1][7:3]};
   assign raw[2] = {frame_ff[4][0], frame_ff[3], frame_ff[2][7:6]};
   assign raw[3] = {frame_ff[5][3:0], frame_ff[4][7:1]};

   // Next-state logic
   always_comb begin
      pos_in     = pos_ff;
      silence_in = silence_ff;
      flag_in    = flag_ff;
      lock_in    = lock_ff;
      stick_in   = stick_ff;
      sw_in      = sw_ff;
      valid_in   = valid_ff & rsp_stall;
      if (issue) begin
         if (is_byte) begin
            if (pos_ff < POS_FULL) begin
               pos_in = pos_ff + 3'd1;
            end
         end else if (is_frame) begin
            stick_in[0] = shrink(raw[0], cfg.deadzone_width);
            stick_in[3] = shrink(raw[1], cfg.deadzone_width);
            stick_in[2] = shrink(raw[2], cfg.deadzone_width);
            stick_in[1] = shrink(raw[3], cfg.deadzone_width);
            sw_in[0]    = frame_ff[5][7:6];
            sw_in[1]    = frame_ff[5][5:4];
            lock_in     = (frame_ff[5][5:4] == SW_LOCK);
            pos_in      = 3'd0;
            silence_in  = 16'd0;
            flag_in     = 1'b0;
            valid_in    = 1'b1;
         end else if (is_tick) begin
            lock_in  = 1'b0;
            valid_in = 1'b1;
            if (cfg.failsafe_enable) begin
               if (silence_ff > cfg.timeout_ticks) begin
                  flag_in = 1'b1;
               end
               if (silence_ff < COUNT_MAX) begin
                  silence_in = silence_ff + 16'd1;
               end
               if (flag_in) begin
                  stick_in[0] = 11'sd0;
                  stick_in[1] = 11'sd0;
                  stick_in[2] = 11'sd0;
                  stick_in[3] = FS_YAW;
                  sw_in[0]    = FS_SW_LEFT;
                  sw_in[1]    = FS_SW_RIGHT;
               end
            end
         end
      end
   end

   // State registers; the decoded values double as the result payload
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAME_LEN; i++) begin
            frame_ff[i] <= 8'd0;
         end
         for (int k = 0; k < 4; k++) begin
            stick_ff[k] <= 11'sd0;
         end
         sw_ff[0]   <= 2'd0;
         sw_ff[1]   <= 2'd0;
         pos_ff     <= 3'd0;
         silence_ff <= 16'd0;
         flag_ff    <= 1'b0;
         lock_ff    <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         if (issue && is_byte && (pos_ff < POS_FULL)) begin
            frame_ff[pos_ff] <= head.data;
         end
         stick_ff   <= stick_in;
         sw_ff      <= sw_in;
         pos_ff     <= pos_in;
         silence_ff <= silence_in;
         flag_ff    <= flag_in;
         lock_ff    <= lock_in;
         valid_ff   <= valid_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_stick_roll     = stick_ff[0];
   assign rsp_stick_pitch    = stick_ff[1];
   assign rsp_stick_throttle = stick_ff[2];
   assign rsp_stick_yaw      = stick_ff[3];
   assign rsp_switch_left    = sw_ff[0];
   assign rsp_switch_right   = sw_ff[1];
   assign rsp_force_lock     = lock_ff;
   assign rsp_out_of_control = flag_ff;

`ifndef NO_ASSERTIONS
   // Byte position never runs past the frame length
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_FULL)
      else $error("byte position past frame end");

   // Failsafe flag always comes with the forced channel values
   a_failsafe_values: assert property (@(posedge clock) disable iff (reset)
      flag_ff |-> (stick_ff[3] == FS_YAW && sw_ff[0] == FS_SW_LEFT &&
                   sw_ff[1] == FS_SW_RIGHT && stick_ff[0] == 11'sd0))
      else $error("failsafe active without forced values");

   // Disarm request only with the right switch in the lock position
   a_lock_switch: assert property (@(posedge clock) disable iff (reset)
      lock_ff |-> (sw_ff[1] == SW_LOCK))
      else $error("force lock without lock switch position");

   // A frame end clears the silence counter and the failsafe
   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      (issue && is_frame) |=> (silence_ff == 16'd0 && !flag_ff))
      else $error("frame end did not clear silence state");

   // Results never change state while the receiver stalls
   a_no_issue_stalled: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall && issue) |-> is_byte)
      else $error("result overwritten while stalled");
`endif

endmodule

[hw/rtl/rc_receiver_frame_decoder.sv]
// ----------------------------------------------------------------------------
// rc_receiver_frame_decoder
// Remote-control receiver frame decoder: bytes, frame-end and tick commands
// in; decoded sticks, switches and failsafe status out.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): cmd 0 carries a received byte, cmd 1 marks a
//    frame end (line idle), cmd 2 is a timer tick; cmd 3 is accepted and
//    dropped. A transaction is taken when req_valid is high and req_stall low.
//  - Result channel (rsp_*): one transaction per frame end or tick, none for
//    a byte. The receiver holds it with rsp_stall; the fields stay stable.
//  - Path: a frame-end or tick result passes the input hold register, the
//    queue and the execution register before it is valid.
//  - Throughput: one request per cycle while req_stall is low; the back end
//    executes one queued operation per cycle, only bytes if a result stalls.
//  - A stalled receiver backs up the queue (QUEUE_DEPTH entries) and then
//    the input hold register, after which req_stall rises.
//  - Configuration via the csr_ APB port: failsafe enable at 0x0, timeout
//    ticks at 0x4, deadzone width at 0x8. Write only while idle.
//  - Reset (synchronous, active high) clears the frame store, the decoded
//    values, the silence counter and failsafe flag, and loads register
//    defaults (enable 1, timeout 100, deadzone 5).
// ----------------------------------------------------------------------------
module rc_receiver_frame_decoder import rcfd_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   // Request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [7:0]         req_rx_byte,
   // Result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [10:0] rsp_stick_roll,
   output logic signed [10:0] rsp_stick_pitch,
   output logic signed [10:0] rsp_stick_throttle,
   output logic signed [10:0] rsp_stick_yaw,
   output logic [1:0]         rsp_switch_left,
   output logic [1:0]         rsp_switch_right,
   output logic               rsp_force_lock,
   output logic               rsp_out_of_control,
   // Configuration port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   push_type   push;
   qstat_type  qstat;
   entry_type  head;
   logic       pop;
   cfg_type    cfg;

   logic        enable_ff, enable_in;
   logic [15:0] timeout_ff, timeout_in;
   logic [5:0]  deadzone_ff, deadzone_in;
   logic        csr_write;
   logic [1:0]  csr_index;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      enable_in   = enable_ff;
      timeout_in  = timeout_ff;
      deadzone_in = deadzone_ff;
      if (csr_write) begin
         case (csr_index)
            REG_FAILSAFE_ENABLE: enable_in   = csr_pwdata[0];
            REG_TIMEOUT_TICKS:   timeout_in  = csr_pwdata[15:0];
            REG_DEADZONE_WIDTH:  deadzone_in = csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= RST_FAILSAFE_ENABLE;
         timeout_ff  <= RST_TIMEOUT_TICKS;
         deadzone_ff <= RST_DEADZONE_WIDTH;
      end else begin
         enable_ff   <= enable_in;
         timeout_ff  <= timeout_in;
         deadzone_ff <= deadzone_in;
      end
   end

   // Register readback
   always_comb begin
      case (csr_index)
         REG_FAILSAFE_ENABLE: csr_prdata = {31'd0, enable_ff};
         REG_TIMEOUT_TICKS:   csr_prdata = {16'd0, timeout_ff};
         REG_DEADZONE_WIDTH:  csr_prdata = {26'd0, deadzone_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   assign cfg.failsafe_enable = enable_ff;
   assign cfg.timeout_ticks   = timeout_ff;
   assign cfg.deadzone_width  = deadzone_ff;

   // Front end: accept and classify
   rcfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cmd     (req_cmd),
      .req_rx_byte (req_rx_byte),
      .qstat       (qstat),
      .push        (push)
   );

   // Decoupling queue
   rcfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .qstat (qstat)
   );

   // Back end: decode, failsafe and result
   rcfd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .head               (head),
      .qstat              (qstat),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_stick_roll     (rsp_stick_roll),
      .rsp_stick_pitch    (rsp_stick_pitch),
      .rsp_stick_throttle (rsp_stick_throttle),
      .rsp_stick_yaw      (rsp_stick_yaw),
      .rsp_switch_left    (rsp_switch_left),
      .rsp_switch_right   (rsp_switch_right),
      .rsp_force_lock     (rsp_force_lock),
      .rsp_out_of_control (rsp_out_of_control)
   );

endmodule

[bench/rcfd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfd_checker
// Passive checker for the RC frame decoder. It snoops register writes and
// accepted requests, keeps its own copy of the decoder state, queues the
// decoded outputs each frame end or tick should produce, and compares every
// accepted result field by field against the oldest queued entry.
// ----------------------------------------------------------------------------
module rcfd_checker import rcfd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // Request channel
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [7:0]         req_rx_byte,
   // Result channel
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [10:0] rsp_stick_roll,
   input  logic signed [10:0] rsp_stick_pitch,
   input  logic signed [10:0] rsp_stick_throttle,
   input  logic signed [10:0] rsp_stick_yaw,
   input  logic [1:0]         rsp_switch_left,
   input  logic [1:0]         rsp_switch_right,
   input  logic               rsp_force_lock,
   input  logic               rsp_out_of_control,
   // Configuration port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   input  logic               csr_pready,
   // Status toward the testbench top
   output int                 mismatch_count,
   output int                 outputs_pending,
   output int                 outputs_checked
);

   // Decoded outputs of one frame end or tick
   typedef struct packed {
      logic signed [10:0] roll;
      logic signed [10:0] pitch;
      logic signed [10:0] throttle;
      logic signed [10:0] yaw;
      logic [1:0]         sw_left;
      logic [1:0]         sw_right;
      logic               lock;
      logic               lost;
   } rc_outputs_type;

   rc_outputs_type decoded_q[$];

   // Shadow configuration
   logic        fs_enable;
   logic [15:0] timeout_ticks;
   logic [5:0]  deadzone;

   // Shadow decoder state
   logic [7:0]         frame_store [FRAME_LEN];
   int                 byte_pos;
   logic signed [10:0] channel [4];
   logic [1:0]         switch_pos [2];
   logic [15:0]        silence;
   logic               lost_link;

   // Center a raw stick and shrink it toward zero by the deadzone
   function automatic logic signed [10:0] center_deadzone(input logic [10:0] raw);
      int v;
      v = int'(raw) - int'(CENTER);
      if (v > 0) begin
         v = v - int'(deadzone);
         if (v < 0) v = 0;
      end else begin
         v = v + int'(deadzone);
         if (v > 0) v = 0;
      end
      return v[10:0];
   endfunction

   function automatic rc_outputs_type snapshot(input logic lock);
      rc_outputs_type r;
      r.roll     = channel[0];
      r.pitch    = channel[1];
      r.throttle = channel[2];
      r.yaw      = channel[3];
      r.sw_left  = switch_pos[0];
      r.sw_right = switch_pos[1];
      r.lock     = lock;
      r.lost     = lost_link;
      return r;
   endfunction

   // Advance the shadow state by one accepted request
   task automatic decode_request(input logic [1:0] cmd, input logic [7:0] data);
      logic [10:0] raw0, raw1, raw2, raw3;
      case (cmd)
         CMD_BYTE: begin
            if (byte_pos < FRAME_LEN) begin
               frame_store[byte_pos] = data;
               byte_pos++;
            end
         end
         CMD_FRAME_END: begin
            raw0 = {frame_store[1][2:0], frame_store[0]};
            raw1 = {frame_store[2][5:0], frame_store[1][7:3]};
            raw2 = {frame_store[4][0], frame_store[3], frame_store[2][7:6]};
            raw3 = {frame_store[5][3:0], frame_store[4][7:1]};
            // raw stick 1 and 3 swap places
            channel[0]    = center_deadzone(raw0);
            channel[3]    = center_deadzone(raw1);
            channel[2]    = center_deadzone(raw2);
            channel[1]    = center_deadzone(raw3);
            switch_pos[0] = frame_store[5][7:6];
            switch_pos[1] = frame_store[5][5:4];
            byte_pos      = 0;
            silence       = '0;
            lost_link     = 1'b0;
            decoded_q.push_back(snapshot(switch_pos[1] == SW_LOCK));
         end
         CMD_TICK: begin
            if (fs_enable) begin
               if (silence > timeout_ticks) lost_link = 1'b1;
               if (silence < COUNT_MAX) silence++;
               if (lost_link) begin
                  channel[0]    = '0;
                  channel[1]    = '0;
                  channel[2]    = '0;
                  channel[3]    = FS_YAW;
                  switch_pos[0] = FS_SW_LEFT;
                  switch_pos[1] = FS_SW_RIGHT;
               end
            end
            decoded_q.push_back(snapshot(1'b0));
         end
         default: ;  // unused command: dropped
      endcase
   endtask

   task automatic check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   // Snoop, predict and compare at every edge
   always @(posedge clock) begin
      rc_outputs_type exp_r;
      if (reset) begin
         fs_enable     = RST_FAILSAFE_ENABLE;
         timeout_ticks = RST_TIMEOUT_TICKS;
         deadzone      = RST_DEADZONE_WIDTH;
         foreach (frame_store[i]) frame_store[i] = '0;
         foreach (channel[i]) channel[i] = '0;
         switch_pos[0] = '0;
         switch_pos[1] = '0;
         byte_pos      = 0;
         silence       = '0;
         lost_link     = 1'b0;
         decoded_q.delete();
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_FAILSAFE_ENABLE: fs_enable     = csr_pwdata[0];
               REG_TIMEOUT_TICKS:   timeout_ticks = csr_pwdata[15:0];
               REG_DEADZONE_WIDTH:  deadzone      = csr_pwdata[5:0];
               default: ;
            endcase
         end
         // accepted request
         if (req_valid && !req_stall) decode_request(req_cmd, req_rx_byte);
         // accepted result
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               $error("result transaction with no expected output waiting");
               mismatch_count++;
            end else begin
               exp_r = decoded_q.pop_front();
               check_field("stick_roll", int'(exp_r.roll), int'(rsp_stick_roll));
               check_field("stick_pitch", int'(exp_r.pitch), int'(rsp_stick_pitch));
               check_field("stick_throttle", int'(exp_r.throttle),
                           int'(rsp_stick_throttle));
               check_field("stick_yaw", int'(exp_r.yaw), int'(rsp_stick_yaw));
               check_field("switch_left", int'(exp_r.sw_left), int'(rsp_switch_left));
               check_field("switch_right", int'(exp_r.sw_right), int'(rsp_switch_right));
               check_field("force_lock", int'(exp_r.lock), int'(rsp_force_lock));
               check_field("out_of_control", int'(exp_r.lost), int'(rsp_out_of_control));
               outputs_checked++;
            end
         end
      end
      outputs_pending = decoded_q.size();
   end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the RC frame decoder. Drives directed frames
// (empty, short, overlong, deadzone edges, unused command), then random
// frame/tick traffic under several register settings including the extremes
// and a failsafe trip and recovery run, with random idle and stall cycles.
// ----------------------------------------------------------------------------
module testbench;
   import rcfd_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_cmd = CMD_BYTE;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [10:0] rsp_stick_roll;
   logic signed [10:0] rsp_stick_pitch;
   logic signed [10:0] rsp_stick_throttle;
   logic signed [10:0] rsp_stick_yaw;
   logic [1:0]         rsp_switch_left;
   logic [1:0]         rsp_switch_right;
   logic               rsp_force_lock;
   logic               rsp_out_of_control;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [3:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   int   mismatch_count;
   int   outputs_pending;
   int   outputs_checked;
   int   requests_sent = 0;
   int   reg_writes = 0;
   logic calm = 1'b0;  // high: no idle or stall cycles

   always #5 clock = ~clock;

   rc_receiver_frame_decoder u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_stick_roll     (rsp_stick_roll),
      .rsp_stick_pitch    (rsp_stick_pitch),
      .rsp_stick_throttle (rsp_stick_throttle),
      .rsp_stick_yaw      (rsp_stick_yaw),
      .rsp_switch_left    (rsp_switch_left),
      .rsp_switch_right   (rsp_switch_right),
      .rsp_force_lock     (rsp_force_lock),
      .rsp_out_of_control (rsp_out_of_control),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   rcfd_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_stick_roll     (rsp_stick_roll),
      .rsp_stick_pitch    (rsp_stick_pitch),
      .rsp_stick_throttle (rsp_stick_throttle),
      .rsp_stick_yaw      (rsp_stick_yaw),
      .rsp_switch_left    (rsp_switch_left),
      .rsp_switch_right   (rsp_switch_right),
      .rsp_force_lock     (rsp_force_lock),
      .rsp_out_of_control (rsp_out_of_control),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_pready         (csr_pready),
      .mismatch_count     (mismatch_count),
      .outputs_pending    (outputs_pending),
      .outputs_checked    (outputs_checked)
   );

   // Random result backpressure
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 27);
   end

   // One request transaction, with random idle cycles ahead of it
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] data);
      logic taken;
      while (!calm && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_rx_byte <= data;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      if (cmd != CMD_UNUSED) requests_sent++;
   endtask

   // Stop sending and wait until every expected output is back
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outputs_pending != 0);
      repeat (8) @(posedge clock);
   endtask

   // Register write: setup then access phase
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_pready);
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      reg_writes++;
   endtask

   task automatic set_config(input logic en, input logic [15:0] tmo, input logic [5:0] dz);
      drain();
      csr_write(REG_FAILSAFE_ENABLE, 32'(en));
      csr_write(REG_TIMEOUT_TICKS, 32'(tmo));
      csr_write(REG_DEADZONE_WIDTH, 32'(dz));
   endtask

   // Pack four raw sticks and two switches into the 48-bit frame layout
   function automatic logic [47:0] pack_frame(input logic [10:0] r0, r1, r2, r3,
                                              input logic [1:0] left, right);
      return {left, right, r3, r2, r1, r0};
   endfunction

   // Raw stick value biased toward the ends and the center
   function automatic logic [10:0] rand_raw();
      int pick;
      pick = $urandom_range(7);
      if (pick == 0) return 11'd0;
      if (pick == 1) return 11'd2047;
      if (pick < 4) return 11'(1024 - 70 + $urandom_range(140));
      return 11'($urandom);
   endfunction

   task automatic send_frame(input logic [47:0] bits, input int extra);
      for (int k = 0; k < 6; k++) send_item(CMD_BYTE, bits[8*k +: 8]);
      repeat (extra) send_item(CMD_BYTE, 8'($urandom));
      send_item(CMD_FRAME_END, 8'($urandom));
   endtask

   // Mostly whole frames and tick bursts, some broken frames and noise
   task automatic random_traffic(input int n, input int long_burst);
      int goal, pick, len;
      goal = requests_sent + n;
      while (requests_sent < goal) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_frame(pack_frame(rand_raw(), rand_raw(), rand_raw(), rand_raw(),
                                  2'($urandom_range(3)), 2'($urandom_range(3))),
                       ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0);
         end else if (pick < 80) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(1, long_burst)
                                           : $urandom_range(1, 6);
            repeat (len) send_item(CMD_TICK, 8'($urandom));
         end else if (pick < 90) begin
            len = $urandom_range(0, 8);
            repeat (len) send_item(CMD_BYTE, 8'($urandom));
            send_item(CMD_FRAME_END, 8'($urandom));
         end else if (pick < 95) begin
            send_item(CMD_UNUSED, 8'($urandom));
         end else begin
            send_item(CMD_FRAME_END, 8'($urandom));
         end
      end
   endtask

   // Stimulus
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: tick after reset, empty frame, overlong frame, short frame
      send_item(CMD_TICK, 8'h00);
      send_item(CMD_FRAME_END, 8'hFF);
      send_frame(48'hFFFF_FFFF_FFFF, 1);
      send_item(CMD_BYTE, 8'h00);
      send_item(CMD_BYTE, 8'h00);
      send_item(CMD_FRAME_END, 8'h00);
      send_item(CMD_UNUSED, 8'hA5);
      // deadzone edges around center with the disarm switch position
      send_frame(pack_frame(11'd1024, 11'd1029, 11'd1019, 11'd1030, 2'd1, SW_LOCK), 0);

      // random phases across register settings
      random_traffic(250, 130);
      set_config(1'b1, 16'd0, 6'd0);
      random_traffic(250, 5);
      set_config(1'b1, 16'd60000, 6'd63);
      random_traffic(250, 20);
      set_config(1'b0, 16'd2, 6'd17);
      random_traffic(250, 20);
      set_config(1'b1, 16'($urandom_range(30)), 6'($urandom_range(63)));
      calm = 1'b1;
      random_traffic(200, 60);
      drain();  // sender holds off until all outputs are back
      random_traffic(200, 60);

      // failsafe trips, stays latched under a larger timeout, then checks off
      set_config(1'b1, 16'd24, 6'd5);
      send_item(CMD_FRAME_END, 8'h00);
      repeat (30) send_item(CMD_TICK, 8'($urandom));
      drain();
      csr_write(REG_TIMEOUT_TICKS, 32'd60000);
      repeat (2) send_item(CMD_TICK, 8'h00);
      drain();
      csr_write(REG_FAILSAFE_ENABLE, 32'd0);
      repeat (3) send_item(CMD_TICK, 8'h00);
      send_item(CMD_FRAME_END, 8'h00);
      calm = 1'b0;

      set_config(1'b1, 16'd9, 6'd1);
      random_traffic(250, 30);

      drain();
      $display("covered %0d requests, %0d outputs checked, %0d register writes",
               requests_sent, outputs_checked, reg_writes);
      $display("frames of all lengths, deadzone 0..63, timeout 0..60000, failsafe trip");
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(2_000_000);
      $display("status: fail");
      $finish;
   end

endmodule
